// ===== rtl/ith_pkg.sv =====
// Shared types and constants of the initial tetrahedron block.
// No dependencies; every other file refers to it by scoped names.
package ith_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF = 16;

  localparam logic CMD_SEED  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam int               STEP_BITS       = 3;
  localparam logic [STEP_BITS-1:0] STEP_LAST_ISSUE = 3'd5;
  localparam logic [STEP_BITS-1:0] STEP_DONE       = 3'd7;

  localparam logic [1:0] SEEDS_FULL = 2'd3;
  localparam logic [1:0] FACE_LAST  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CROSS,
    ST_DOT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  typedef struct packed {
    logic    valid;
    logic    shift;
    mac_op_t op;
  } mac_ctl_t;

endpackage

// ===== rtl/ith_if.sv =====
// Valid/ready channel interfaces for point items and triangle items.
// Depends on ith_pkg for default widths.
interface ith_in_if #(
  parameter int COORD_BITS = ith_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = ith_pkg::INDEX_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic        [INDEX_BITS-1:0] point_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         final_point;

  modport source (
    output valid, command, point_index, coord_x, coord_y, coord_z, final_point,
    input  ready
  );
  modport sink (
    input  valid, command, point_index, coord_x, coord_y, coord_z, final_point,
    output ready
  );
endinterface

interface ith_out_if #(
  parameter int INDEX_BITS = ith_pkg::INDEX_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] vertex_first;
  logic [INDEX_BITS-1:0] vertex_second;
  logic [INDEX_BITS-1:0] vertex_third;
  logic                  no_fourth;
  logic                  last_face;

  modport source (
    output valid, vertex_first, vertex_second, vertex_third, no_fourth, last_face,
    input  ready
  );
  modport sink (
    input  valid, vertex_first, vertex_second, vertex_third, no_fourth, last_face,
    output ready
  );
endinterface

// ===== rtl/ith_mac.sv =====
// Shared signed multiply-accumulate unit: registered product, then accumulate.
// Depends on ith_pkg (mac_ctl_t, mac_op_t).
module ith_mac #(
  parameter int COORD_BITS = ith_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ith_pkg::mac_ctl_t              ctl,
  input  logic signed [COORD_BITS+1:0]   op_a,
  input  logic signed [COORD_BITS:0]     op_b,
  output logic signed [3*COORD_BITS+5:0] acc
);

  localparam int PROD_W = 2*COORD_BITS + 3;
  localparam int SPLIT  = COORD_BITS + 1;
  localparam int ACC_W  = 3*COORD_BITS + 6;

  logic signed [PROD_W-1:0] prod_r;
  ith_pkg::mac_ctl_t        ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod_r <= op_a * op_b;
    end
  end

  // high half of the split normal carries weight 2^SPLIT
  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    term     = ctl_r.shift ? (prod_ext <<< SPLIT) : prod_ext;
  end

  always_ff @(posedge clk) begin
    if (ctl_r.valid) begin
      unique case (ctl_r.op)
        ith_pkg::MAC_LOAD: acc_r <= term;
        ith_pkg::MAC_ADD:  acc_r <= acc_r + term;
        ith_pkg::MAC_SUB:  acc_r <= acc_r - term;
        default:           acc_r <= acc_r;
      endcase
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/initial_tetrahedron_from_triangle.sv =====
// Initial simplex builder: base triangle seeds, farthest-point search, four faces.
// Depends on ith_pkg, ith_if (ith_in_if, ith_out_if) and ith_mac.
//
//  channel | direction | handshake         | payload
//  in_ch   | input     | valid/ready, sink | command, point_index, coord_x/y/z, final_point
//  out_ch  | output    | valid/ready, src  | vertex_first/second/third, no_fourth, last_face
//
// The first two seeds are only stored; the third seed also forms the normal from six products.
// A scored candidate is accepted, then its six products pass through the one shared
// multiplier and the product and accumulate registers, with the compare at the last step.
// A point whose index matches a seed received so far is not scored.
// A final point then emits four items, one per cycle while out_ch.ready is high;
// input stays not ready until the fourth is taken, and the run state clears then.
// Synchronous active-low reset clears all run state.
module initial_tetrahedron_from_triangle #(
  parameter int COORD_BITS = ith_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = ith_pkg::INDEX_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ith_in_if.sink    in_ch,
  ith_out_if.source out_ch
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int OPA_W  = COORD_BITS + 2;
  localparam int NRM_W  = 2*COORD_BITS + 3;
  localparam int SPLIT  = COORD_BITS + 1;
  localparam int ACC_W  = 3*COORD_BITS + 6;

  ith_pkg::state_t state_r, state_nxt;
  logic [ith_pkg::STEP_BITS-1:0] st_r, st_nxt;
  logic [1:0] fc_r, fc_nxt;

  logic [INDEX_BITS-1:0]    seed_idx_r [3];
  logic [1:0]               seed_cnt_r;
  logic signed [COORD_BITS-1:0] org_r [3];
  logic signed [COORD_BITS-1:0] sec_r [3];
  logic signed [DIFF_W-1:0] diff_r [3];
  logic signed [NRM_W-1:0]  nrm_r [3];
  logic [ACC_W-1:0]         best_mag_r;
  logic                     best_neg_r;
  logic [INDEX_BITS-1:0]    best_idx_r;
  logic                     found_r;
  logic [INDEX_BITS-1:0]    cur_idx_r;
  logic                     cur_final_r;

  logic signed [COORD_BITS-1:0] in_p [3];
  logic signed [DIFF_W-1:0] in_diff [3];
  logic signed [DIFF_W-1:0] u [3];
  logic                     take_in;
  logic                     take_out;
  logic                     skip;
  logic                     run_done;

  ith_pkg::mac_ctl_t        mac_ctl;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [DIFF_W-1:0] op_b;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         acc_mag;
  logic                     acc_neg;

  logic signed [DIFF_W-1:0] u_a;
  logic signed [NRM_W-1:0]  nrm_sel;
  logic signed [DIFF_W-1:0] diff_sel;

  logic [INDEX_BITS-1:0]    v0, v1, v2;

  assign take_in  = in_ch.valid && in_ch.ready;
  assign take_out = out_ch.valid && out_ch.ready;
  assign run_done = take_out && (fc_r == ith_pkg::FACE_LAST);

  assign in_p[0] = in_ch.coord_x;
  assign in_p[1] = in_ch.coord_y;
  assign in_p[2] = in_ch.coord_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_diff[k] = {in_p[k][COORD_BITS-1], in_p[k]} - {org_r[k][COORD_BITS-1], org_r[k]};
      u[k]       = {sec_r[k][COORD_BITS-1], sec_r[k]} - {org_r[k][COORD_BITS-1], org_r[k]};
    end
  end

  // only the seeds received so far are excluded
  assign skip = ((seed_cnt_r > 2'd0) && (seed_idx_r[0] == in_ch.point_index)) ||
                ((seed_cnt_r > 2'd1) && (seed_idx_r[1] == in_ch.point_index)) ||
                ((seed_cnt_r > 2'd2) && (seed_idx_r[2] == in_ch.point_index));

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ith_pkg::ST_IDLE;
      st_r    <= '0;
      fc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      fc_r    <= fc_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    fc_nxt        = fc_r;
    mac_ctl.valid = 1'b0;
    mac_ctl.shift = 1'b0;
    mac_ctl.op    = ith_pkg::MAC_LOAD;
    unique case (state_r)
      ith_pkg::ST_IDLE: begin
        if (take_in) begin
          st_nxt = '0;
          fc_nxt = '0;
          if (in_ch.command == ith_pkg::CMD_SEED) begin
            if (seed_cnt_r == 2'd2) begin
              state_nxt = ith_pkg::ST_CROSS;
            end
          end else if (!skip) begin
            state_nxt = ith_pkg::ST_DOT;
          end else if (in_ch.final_point) begin
            state_nxt = ith_pkg::ST_EMIT;
          end
        end
      end
      ith_pkg::ST_CROSS: begin
        // load the first product of each component, subtract the second
        mac_ctl.valid = (st_r <= ith_pkg::STEP_LAST_ISSUE);
        mac_ctl.op    = st_r[0] ? ith_pkg::MAC_SUB : ith_pkg::MAC_LOAD;
        st_nxt        = st_r + 1'b1;
        if (st_r == ith_pkg::STEP_DONE) begin
          state_nxt = ith_pkg::ST_IDLE;
        end
      end
      ith_pkg::ST_DOT: begin
        mac_ctl.valid = (st_r <= ith_pkg::STEP_LAST_ISSUE);
        mac_ctl.shift = !st_r[0];
        mac_ctl.op    = (st_r == '0) ? ith_pkg::MAC_LOAD : ith_pkg::MAC_ADD;
        st_nxt        = st_r + 1'b1;
        if (st_r == ith_pkg::STEP_DONE) begin
          state_nxt = cur_final_r ? ith_pkg::ST_EMIT : ith_pkg::ST_IDLE;
        end
      end
      ith_pkg::ST_EMIT: begin
        if (take_out) begin
          fc_nxt = fc_r + 1'b1;
          if (fc_r == ith_pkg::FACE_LAST) begin
            state_nxt = ith_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = ith_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- operands
  always_comb begin
    unique case (st_r)
      3'd0:    begin u_a = u[1]; end
      3'd1:    begin u_a = u[2]; end
      3'd2:    begin u_a = u[2]; end
      3'd3:    begin u_a = u[0]; end
      3'd4:    begin u_a = u[0]; end
      default: begin u_a = u[1]; end
    endcase
    unique case (st_r[2:1])
      2'd0:    begin nrm_sel = nrm_r[0]; diff_sel = diff_r[0]; end
      2'd1:    begin nrm_sel = nrm_r[1]; diff_sel = diff_r[1]; end
      default: begin nrm_sel = nrm_r[2]; diff_sel = diff_r[2]; end
    endcase
    if (state_r == ith_pkg::ST_CROSS) begin
      op_a = {u_a[DIFF_W-1], u_a};
      unique case (st_r)
        3'd0, 3'd3: op_b = diff_r[2];
        3'd1, 3'd4: op_b = diff_r[1];
        default:    op_b = diff_r[0];
      endcase
    end else begin
      // normal split into signed high part and unsigned low SPLIT bits
      op_a = st_r[0] ? {1'b0, nrm_sel[SPLIT-1:0]} : nrm_sel[NRM_W-1:SPLIT];
      op_b = diff_sel;
    end
  end

  ith_mac #(
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  assign acc_neg = acc[ACC_W-1];
  assign acc_mag = acc_neg ? (~acc + 1'b1) : acc;

  // ---------------------------------------------------------------- run state
  always_ff @(posedge clk) begin
    if (!rst_n || run_done) begin
      for (int k = 0; k < 3; k++) begin
        seed_idx_r[k] <= '0;
        org_r[k]      <= '0;
        nrm_r[k]      <= '0;
      end
      seed_cnt_r <= '0;
      best_mag_r <= '0;
      best_neg_r <= 1'b0;
      best_idx_r <= '0;
      found_r    <= 1'b0;
    end else begin
      if (take_in) begin
        if (in_ch.command == ith_pkg::CMD_SEED) begin
          if (seed_cnt_r != ith_pkg::SEEDS_FULL) begin
            seed_idx_r[seed_cnt_r] <= in_ch.point_index;
            seed_cnt_r             <= seed_cnt_r + 1'b1;
            if (seed_cnt_r == 2'd0) begin
              for (int k = 0; k < 3; k++) org_r[k] <= in_p[k];
            end
          end
        end else if (!skip) begin
          found_r <= 1'b1;
        end
      end
      if (state_r == ith_pkg::ST_CROSS) begin
        unique case (st_r)
          3'd3:    nrm_r[0] <= acc[NRM_W-1:0];
          3'd5:    nrm_r[1] <= acc[NRM_W-1:0];
          3'd7:    nrm_r[2] <= acc[NRM_W-1:0];
          default: ;
        endcase
      end
      // equal magnitude: later point wins
      if (state_r == ith_pkg::ST_DOT && st_r == ith_pkg::STEP_DONE &&
          acc_mag >= best_mag_r) begin
        best_mag_r <= acc_mag;
        best_neg_r <= acc_neg;
        best_idx_r <= cur_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      for (int k = 0; k < 3; k++) diff_r[k] <= in_diff[k];
      cur_idx_r   <= in_ch.point_index;
      cur_final_r <= in_ch.final_point;
      if (in_ch.command == ith_pkg::CMD_SEED && seed_cnt_r == 2'd1) begin
        for (int k = 0; k < 3; k++) sec_r[k] <= in_p[k];
      end
    end
  end

  // ---------------------------------------------------------------- faces
  always_comb begin
    unique case (fc_r)
      2'd0: begin
        v0 = seed_idx_r[0];
        v1 = best_neg_r ? seed_idx_r[2] : seed_idx_r[1];
        v2 = best_neg_r ? seed_idx_r[1] : seed_idx_r[2];
      end
      2'd1: begin
        v0 = best_neg_r ? seed_idx_r[1] : seed_idx_r[0];
        v1 = best_neg_r ? seed_idx_r[0] : seed_idx_r[1];
        v2 = best_idx_r;
      end
      2'd2: begin
        v0 = best_neg_r ? seed_idx_r[2] : seed_idx_r[1];
        v1 = best_neg_r ? seed_idx_r[1] : seed_idx_r[2];
        v2 = best_idx_r;
      end
      default: begin
        v0 = best_neg_r ? seed_idx_r[0] : seed_idx_r[2];
        v1 = best_neg_r ? seed_idx_r[2] : seed_idx_r[0];
        v2 = best_idx_r;
      end
    endcase
  end

  assign in_ch.ready          = (state_r == ith_pkg::ST_IDLE);
  assign out_ch.valid         = (state_r == ith_pkg::ST_EMIT);
  assign out_ch.vertex_first  = v0;
  assign out_ch.vertex_second = v1;
  assign out_ch.vertex_third  = v2;
  assign out_ch.no_fourth     = !found_r;
  assign out_ch.last_face     = (fc_r == ith_pkg::FACE_LAST);

`ifndef NO_ASSERTIONS
  a_in_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while faces are pending");

  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ith_pkg::ST_DOT && st_r == ith_pkg::STEP_DONE && cur_final_r)
    |=> out_ch.valid)
    else $error("final point did not start emission");

  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_face)
    |=> (seed_cnt_r == 2'd0 && !found_r && best_mag_r == '0))
    else $error("run state not cleared after last face");

  a_no_fourth_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.no_fourth && fc_r != 2'd0) |-> (out_ch.vertex_third == '0))
    else $error("fourth vertex nonzero without candidate");
`endif

endmodule
